// ===== hw/rtl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the preemptive EDF scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TAG_BITS_DEF  = 8;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 112;

    localparam logic       OP_ARRIVE = 1'b0;
    localparam logic       OP_TICK   = 1'b1;

    localparam logic [1:0] EV_ENTERED  = 2'd0;
    localparam logic [1:0] EV_RUNNING  = 2'd1;
    localparam logic [1:0] EV_FINISHED = 2'd2;
    localparam logic [1:0] EV_REJECTED = 2'd3;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ARRIVE,
        ST_RUN_RD,
        ST_RUN_CAP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWITCH,
        ST_DEC,
        ST_START,
        ST_FIN,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

    typedef struct packed {
        logic ld_in;
        logic check_run;
        logic rd_run;
        logic run_cap;
        logic rd_scan;
        logic scan_cmp;
        logic do_switch;
        logic do_dec;
        logic emit_arr;
        logic emit_start;
        logic emit_fin;
        logic rd_shift;
        logic shift_step;
        logic shift_end;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic scan_more;
        logic start_pend;
        logic fin;
        logic shift_more;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/preemptive_edf_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_edf_scheduler
// Preemptive earliest-deadline-first scheduler over an arrival-ordered table.
// ----------------------------------------------------------------------------
// Tasks live in one table RAM with a single registered read port. An arrive
// word may wait for the result register. A tick word walks the table one
// entry at a time, a read state and then a compare state per stored task,
// and may also wait for the result register; when a task finishes, the gap
// in the table is closed by moving each entry behind it down one slot.
// A new word is taken only when the sequencer is idle, but a finished
// result may still wait in the output register.
`default_nettype none

module preemptive_edf_scheduler
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // task_tag[7:0], run_ticks[23:8], relative_deadline[39:24]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // operation[0]
    input  wire logic [0:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // event_tag[7:0], event_time[39:8], start_delay[71:40],
    // response_span[103:72], on_time[104], zero[111:105]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // event_kind[1:0]
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast
);

    cmd_t        cmd;
    sts_t        sts;
    logic [7:0]  ev_tag;
    logic [31:0] ev_time;
    logic [31:0] ev_wait;
    logic [31:0] ev_turn;
    logic        ev_met;

    edf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_tvalid && s_tready),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    edf_dpath #(
        .MAX_TASKS (MAX_TASKS),
        .TAG_BITS  (TAG_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser[0]),
        .in_tag    (s_tdata[7:0]),
        .in_svc    (s_tdata[23:8]),
        .in_rel    (s_tdata[39:24]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_tag   (ev_tag),
        .out_time  (ev_time),
        .out_wait  (ev_wait),
        .out_turn  (ev_turn),
        .out_met   (ev_met),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, ev_met, ev_turn, ev_wait, ev_time, ev_tag};

endmodule

`default_nettype wire

// ===== hw/rtl/edf_ram.sv =====
// ----------------------------------------------------------------------------
// edf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/edf_ctrl.sv =====
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer of the EDF scheduler: arrival, scan, switch, tick and removal.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_ctrl
    import edf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_fire) state_next = ST_DISPATCH;
            ST_DISPATCH: state_next = (sts.op == OP_ARRIVE) ? ST_ARRIVE : ST_RUN_RD;
            ST_ARRIVE:   if (!sts.out_busy) state_next = ST_IDLE;
            ST_RUN_RD:   state_next = ST_RUN_CAP;
            ST_RUN_CAP:  state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = sts.scan_more ? ST_SCAN_CMP : ST_SWITCH;
            ST_SCAN_CMP: state_next = ST_SCAN_RD;
            ST_SWITCH:   state_next = ST_DEC;
            ST_DEC:      state_next = ST_START;
            ST_START:    if (!sts.start_pend || !sts.out_busy) state_next = ST_FIN;
            ST_FIN:
            begin
                if (!sts.fin)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: state_next = sts.shift_more ? ST_SHIFT_WR : ST_IDLE;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.ld_in  = in_fire;
            end
            ST_DISPATCH: cmd.check_run  = (sts.op == OP_TICK);
            ST_ARRIVE:   cmd.emit_arr   = !sts.out_busy;
            ST_RUN_RD:   cmd.rd_run     = 1'b1;
            ST_RUN_CAP:  cmd.run_cap    = 1'b1;
            ST_SCAN_RD:  cmd.rd_scan    = sts.scan_more;
            ST_SCAN_CMP: cmd.scan_cmp   = 1'b1;
            ST_SWITCH:   cmd.do_switch  = 1'b1;
            ST_DEC:      cmd.do_dec     = 1'b1;
            ST_START:    cmd.emit_start = sts.start_pend && !sts.out_busy;
            ST_FIN:      cmd.emit_fin   = sts.fin && !sts.out_busy;
            ST_SHIFT_RD:
            begin
                cmd.rd_shift  = sts.shift_more;
                cmd.shift_end = !sts.shift_more;
            end
            ST_SHIFT_WR: cmd.shift_step = 1'b1;
            default:     cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/edf_dpath.sv =====
// ----------------------------------------------------------------------------
// edf_dpath
// Task table, time counter, deadline scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_dpath
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    input  wire logic                  in_op,
    input  wire logic [7:0]            in_tag,
    input  wire logic [15:0]           in_svc,
    input  wire logic [15:0]           in_rel,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_kind,
    output logic [7:0]                 out_tag,
    output logic [31:0]                out_time,
    output logic [31:0]                out_wait,
    output logic [31:0]                out_turn,
    output logic                       out_met,
    output logic                       out_last
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam logic [CNT_W-1:0] NONE_RUNNING = CNT_W'(MAX_TASKS);

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         arrival;
        logic [15:0]         rem;
        logic [31:0]         dl;
        logic [31:0]         frt;
        logic                started;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    logic                op_reg;
    logic [7:0]          tag_reg;
    logic [15:0]         svc_reg;
    logic [15:0]         rel_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    run_reg;
    logic [31:0]         now_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic                best_valid_reg;
    logic [CNT_W-1:0]    best_idx_reg;
    entry_t              best_reg;
    entry_t              run_ent_reg;
    logic                start_pend_reg;
    logic [TAG_BITS-1:0] start_tag_reg;
    logic [31:0]         start_time_reg;
    logic                fin_reg;
    logic [CNT_W-1:0]    shift_reg;
    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [7:0]          out_tag_reg;
    logic [31:0]         out_time_reg;
    logic [31:0]         out_wait_reg;
    logic [31:0]         out_turn_reg;
    logic                out_met_reg;
    logic                out_last_reg;

    entry_t              rd_ent;
    logic [ENT_W-1:0]    rd_data;
    entry_t              wr_ent;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic                rd_en;
    logic                full;
    logic                run_valid;
    logic                do_sw;
    logic [32:0]         dl_sum;
    logic [31:0]         dl_abs;
    logic [31:0]         now_inc;
    logic [15:0]         rem_dec;
    logic [CNT_W-1:0]    shift_nxt;
    entry_t              arr_ent;
    entry_t              dec_ent;
    entry_t              sw_ent;

    assign rd_ent    = entry_t'(rd_data);
    assign full      = (count_reg == CNT_W'(MAX_TASKS));
    assign run_valid = (run_reg < count_reg);
    assign do_sw     = best_valid_reg && (!run_valid || (best_reg.dl < run_ent_reg.dl));
    assign dl_sum    = {1'b0, now_reg} + {17'd0, rel_reg};
    assign dl_abs    = dl_sum[32] ? TIME_MAX : dl_sum[31:0];
    assign now_inc   = (now_reg == TIME_MAX) ? now_reg : now_reg + 32'd1;
    assign rem_dec   = (run_ent_reg.rem != 16'd0) ? run_ent_reg.rem - 16'd1 : 16'd0;
    assign shift_nxt = shift_reg + CNT_W'(1);

    always_comb
    begin
        arr_ent         = '0;
        arr_ent.tag     = TAG_BITS'(tag_reg);
        arr_ent.arrival = now_reg;
        arr_ent.rem     = svc_reg;
        arr_ent.dl      = dl_abs;
        dec_ent         = run_ent_reg;
        dec_ent.rem     = rem_dec;
        // stamp the first run time when the task starts for the first time
        sw_ent          = best_reg;
        sw_ent.started  = 1'b1;
        if (!best_reg.started)
        begin
            sw_ent.frt = now_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_ent  = arr_ent;
        if (cmd.emit_arr && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
        end
        else if (cmd.do_dec && run_valid)
        begin
            wr_en   = 1'b1;
            wr_addr = run_reg[IDX_W-1:0];
            wr_ent  = dec_ent;
        end
        else if (cmd.shift_step)
        begin
            wr_en   = 1'b1;
            wr_addr = shift_reg[IDX_W-1:0];
            wr_ent  = rd_ent;
        end
    end

    always_comb
    begin
        rd_en   = cmd.rd_run || cmd.rd_scan || cmd.rd_shift;
        rd_addr = scan_reg[IDX_W-1:0];
        if (cmd.rd_run)
        begin
            rd_addr = run_reg[IDX_W-1:0];
        end
        else if (cmd.rd_shift)
        begin
            rd_addr = shift_nxt[IDX_W-1:0];
        end
    end

    edf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENT_W'(wr_ent)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            run_reg        <= NONE_RUNNING;
            now_reg        <= '0;
            best_valid_reg <= 1'b0;
            start_pend_reg <= 1'b0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit_arr || cmd.emit_start || cmd.emit_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.emit_arr && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.check_run)
            begin
                // drop a stale running slot before the scan
                if (!run_valid)
                begin
                    run_reg <= NONE_RUNNING;
                end
                best_valid_reg <= 1'b0;
                start_pend_reg <= 1'b0;
                fin_reg        <= 1'b0;
            end
            if (cmd.scan_cmp && (scan_reg != run_reg)
                && (!best_valid_reg || (rd_ent.dl < best_reg.dl)))
            begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.do_switch)
            begin
                now_reg <= now_inc;
                start_pend_reg <= do_sw;
                if (do_sw)
                begin
                    run_reg <= best_idx_reg;
                end
            end
            if (cmd.do_dec)
            begin
                fin_reg <= run_valid && (rem_dec == 16'd0);
            end
            if (cmd.emit_start)
            begin
                start_pend_reg <= 1'b0;
            end
            if (cmd.emit_fin)
            begin
                fin_reg <= 1'b0;
            end
            if (cmd.shift_end)
            begin
                count_reg <= count_reg - CNT_W'(1);
                run_reg   <= NONE_RUNNING;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            op_reg  <= in_op;
            tag_reg <= in_tag;
            svc_reg <= in_svc;
            rel_reg <= in_rel;
        end
        if (cmd.check_run)
        begin
            scan_reg <= '0;
        end
        if (cmd.run_cap)
        begin
            run_ent_reg <= rd_ent;
        end
        if (cmd.scan_cmp)
        begin
            scan_reg <= scan_reg + CNT_W'(1);
            if ((scan_reg != run_reg) && (!best_valid_reg || (rd_ent.dl < best_reg.dl)))
            begin
                best_reg     <= rd_ent;
                best_idx_reg <= scan_reg;
            end
        end
        if (cmd.do_switch && do_sw)
        begin
            run_ent_reg    <= sw_ent;
            start_tag_reg  <= best_reg.tag;
            start_time_reg <= now_reg;
        end
        if (cmd.do_dec)
        begin
            run_ent_reg.rem <= rem_dec;
        end
        if (cmd.emit_fin)
        begin
            shift_reg <= run_reg;
        end
        if (cmd.shift_step)
        begin
            shift_reg <= shift_nxt;
        end
        if (cmd.emit_arr)
        begin
            out_kind_reg <= full ? EV_REJECTED : EV_ENTERED;
            out_tag_reg  <= 8'(TAG_BITS'(tag_reg));
            out_time_reg <= now_reg;
            out_wait_reg <= '0;
            out_turn_reg <= '0;
            out_met_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
        if (cmd.emit_start)
        begin
            out_kind_reg <= EV_RUNNING;
            out_tag_reg  <= 8'(start_tag_reg);
            out_time_reg <= start_time_reg;
            out_wait_reg <= '0;
            out_turn_reg <= '0;
            out_met_reg  <= 1'b0;
            out_last_reg <= !fin_reg;
        end
        if (cmd.emit_fin)
        begin
            out_kind_reg <= EV_FINISHED;
            out_tag_reg  <= 8'(run_ent_reg.tag);
            out_time_reg <= now_reg;
            out_wait_reg <= run_ent_reg.frt - run_ent_reg.arrival;
            out_turn_reg <= now_reg - run_ent_reg.arrival;
            out_met_reg  <= (now_reg <= run_ent_reg.dl);
            out_last_reg <= 1'b1;
        end
    end

    assign sts.op         = op_reg;
    assign sts.scan_more  = (scan_reg < count_reg);
    assign sts.start_pend = start_pend_reg;
    assign sts.fin        = fin_reg;
    assign sts.shift_more = (shift_nxt < count_reg);
    assign sts.out_busy   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_tag   = out_tag_reg;
    assign out_time  = out_time_reg;
    assign out_wait  = out_wait_reg;
    assign out_turn  = out_turn_reg;
    assign out_met   = out_met_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/edf_checker.sv =====
// ----------------------------------------------------------------------------
// edf_checker
// Port-level checks of the EDF scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_checker
    import edf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [1:0]            m_tuser,
    input wire logic                  m_tlast
);

    // hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != EV_FINISHED) |-> (m_tdata[104:40] == '0))
        else $error("statistics set on a non-finished event");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == EV_ENTERED) || (m_tuser == EV_REJECTED)) |-> m_tlast)
        else $error("arrival event not marked last");

    a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a tick still owes a result");

endmodule

bind preemptive_edf_scheduler edf_checker u_edf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the preemptive EDF scheduler: a queue-fed driver
// offers arrive and tick words, a predictor tracks the task table and builds
// the expected events, and a monitor compares every output word against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import edf_pkg::*;

    localparam int NTASK      = 16;
    localparam int NONE_SLOT  = NTASK;
    localparam int HALF_CLK   = 2;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 300;

    typedef struct {
        logic        op;
        logic [7:0]  tag;
        logic [15:0] svc;
        logic [15:0] rel;
        bit          sync;
    } sched_word_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [31:0] at;
        logic [31:0] waited;
        logic [31:0] turn;
        logic        met;
        logic        last;
    } sched_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // task_tag[7:0], run_ticks[23:8], relative_deadline[39:24]
    logic [IN_DATA_W-1:0]  s_tdata;
    // operation[0]
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // event_tag[7:0], event_time[39:8], start_delay[71:40],
    // response_span[103:72], on_time[104], zero[111:105]
    logic [OUT_DATA_W-1:0] m_tdata;
    // event_kind[1:0]
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    preemptive_edf_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sched_word_t  pending_words[$];
    sched_event_t expected_events[$];
    int           errors = 0;
    int           accepted_words = 0;
    bit           offering = 0;

    // shadow task table
    logic [7:0]  tbl_tag[NTASK];
    logic [31:0] tbl_arrival[NTASK];
    logic [15:0] tbl_remain[NTASK];
    logic [31:0] tbl_deadline[NTASK];
    logic [31:0] tbl_first_run[NTASK];
    bit          tbl_started[NTASK];
    int          task_count = 0;
    int          running = NONE_SLOT;
    logic [31:0] now = 32'd0;

    initial clk = 1'b0;
    always #(HALF_CLK) clk = ~clk;

    function automatic sched_event_t make_event(logic [1:0] kind, logic [7:0] tag,
                                                logic [31:0] at, logic [31:0] w,
                                                logic [31:0] tr, logic met);
        sched_event_t e;
        e.kind = kind; e.tag = tag; e.at = at;
        e.waited = w; e.turn = tr; e.met = met; e.last = 1'b0;
        return e;
    endfunction

    function automatic void schedule_word(sched_word_t w);
        sched_event_t ev[$];
        logic [32:0]  dl;
        int           best;
        bit           have_run;
        int           s;
        if (w.op == OP_ARRIVE) begin
            if (task_count >= NTASK) begin
                ev.push_back(make_event(EV_REJECTED, w.tag, now, 0, 0, 1'b0));
            end
            else begin
                s = task_count;
                dl = {1'b0, now} + w.rel;
                tbl_tag[s] = w.tag;
                tbl_arrival[s] = now;
                tbl_remain[s] = w.svc;
                tbl_deadline[s] = dl[32] ? TIME_MAX : dl[31:0];
                tbl_first_run[s] = 32'd0;
                tbl_started[s] = 0;
                task_count++;
                ev.push_back(make_event(EV_ENTERED, w.tag, now, 0, 0, 1'b0));
            end
        end
        else begin
            best = NONE_SLOT;
            have_run = running < task_count;
            if (!have_run)
                running = NONE_SLOT;
            for (int i = 0; i < task_count; i++) begin
                if (i != running &&
                    (best == NONE_SLOT || tbl_deadline[i] < tbl_deadline[best]))
                    best = i;
            end
            if (best != NONE_SLOT &&
                (!have_run || tbl_deadline[best] < tbl_deadline[running])) begin
                running = best;
                if (!tbl_started[best]) begin
                    tbl_started[best] = 1;
                    tbl_first_run[best] = now;
                end
                ev.push_back(make_event(EV_RUNNING, tbl_tag[best], now, 0, 0, 1'b0));
            end
            if (now != TIME_MAX)
                now++;
            if (running < task_count) begin
                s = running;
                if (tbl_remain[s] > 0)
                    tbl_remain[s]--;
                if (tbl_remain[s] == 0) begin
                    ev.push_back(make_event(EV_FINISHED, tbl_tag[s], now,
                                            tbl_first_run[s] - tbl_arrival[s],
                                            now - tbl_arrival[s],
                                            now <= tbl_deadline[s]));
                    running = NONE_SLOT;
                    // close the gap, keep arrival order
                    for (int i = s; i + 1 < task_count; i++) begin
                        tbl_tag[i] = tbl_tag[i + 1];
                        tbl_arrival[i] = tbl_arrival[i + 1];
                        tbl_remain[i] = tbl_remain[i + 1];
                        tbl_deadline[i] = tbl_deadline[i + 1];
                        tbl_first_run[i] = tbl_first_run[i + 1];
                        tbl_started[i] = tbl_started[i + 1];
                    end
                    task_count--;
                end
            end
        end
        if (ev.size() > 0)
            ev[ev.size() - 1].last = 1'b1;
        foreach (ev[i])
            expected_events.push_back(ev[i]);
    endfunction

    function automatic sched_word_t mk_word(logic op, logic [7:0] tag, logic [15:0] svc,
                                            logic [15:0] rel, bit sync);
        sched_word_t w;
        w.op = op; w.tag = tag; w.svc = svc; w.rel = rel; w.sync = sync;
        return w;
    endfunction

    // stimulus
    initial begin
        logic [15:0] svc;
        logic [15:0] rel;
        pending_words.push_back(mk_word(OP_ARRIVE, 8'h00, 16'd1, 16'd0, 0));
        pending_words.push_back(mk_word(OP_TICK, 8'h00, 16'd0, 16'd0, 0));
        pending_words.push_back(mk_word(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 0));
        pending_words.push_back(mk_word(OP_ARRIVE, 8'hFF, 16'hFFFF, 16'hFFFF, 0));
        pending_words.push_back(mk_word(OP_TICK, 8'h00, 16'd0, 16'd0, 0));
        // zero service: finishes on its first running tick
        pending_words.push_back(mk_word(OP_ARRIVE, 8'h55, 16'd0, 16'd3, 0));
        pending_words.push_back(mk_word(OP_ARRIVE, 8'hAA, 16'd2, 16'd1, 0));
        for (int i = 0; i < 4; i++)
            pending_words.push_back(mk_word(OP_TICK, 8'h00, 16'd0, 16'd0, 0));
        // overfill the table to get a rejection
        for (int i = 0; i < 16; i++)
            pending_words.push_back(mk_word(OP_ARRIVE, 8'(8'h10 + i), 16'(1 + i % 3),
                                            16'(i * 2), 0));
        for (int n = 0; n < 950; n++) begin
            svc = ($urandom_range(0, 99) == 0) ? 16'($urandom_range(1, 65535))
                                               : 16'($urandom_range(1, 10));
            rel = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40))
                                              : 16'($urandom);
            pending_words.push_back(mk_word(($urandom_range(0, 99) < 58) ? OP_TICK
                                                                         : OP_ARRIVE,
                                            8'($urandom), svc, rel,
                                            (n % 150) == 149));
        end
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        int          gap;
        bit          burst;
        sched_word_t w;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_ARRIVE;
            offering = 0;
            gap = 0;
            burst = 0;
        end
        else begin
            if (offering && s_tready) begin
                schedule_word(w);
                accepted_words++;
                offering = 0;
                if (accepted_words % 100 == 0)
                    burst = $urandom_range(0, 2) == 0;
                gap = burst ? 0 : $urandom_range(0, 12);
            end
            if (!offering) begin
                if (gap > 0)
                    gap--;
                else if (pending_words.size() > 0 &&
                         (!pending_words[0].sync || expected_events.size() == 0)) begin
                    w = pending_words.pop_front();
                    s_tdata <= {w.rel, w.svc, w.tag};
                    s_tuser <= w.op;
                    offering = 1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        int           stall;
        int           hold_left;
        bit           hold_done;
        sched_event_t e;
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall = 0;
            hold_left = 0;
            hold_done = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word kind=%0d tag=%0h", $time, m_tuser,
                             m_tdata[7:0]);
                end
                else begin
                    e = expected_events.pop_front();
                    if (m_tuser !== e.kind || m_tdata[7:0] !== e.tag ||
                        m_tdata[39:8] !== e.at || m_tdata[71:40] !== e.waited ||
                        m_tdata[103:72] !== e.turn || m_tdata[104] !== e.met ||
                        m_tdata[111:105] !== 7'd0 || m_tlast !== e.last) begin
                        errors++;
                        $display("%0t: expected kind=%0d tag=%0h t=%0d w=%0d ta=%0d met=%0b last=%0b",
                                 $time, e.kind, e.tag, e.at, e.waited, e.turn, e.met, e.last);
                        $display("%0t: actual   kind=%0d tag=%0h t=%0d w=%0d ta=%0d met=%0b last=%0b",
                                 $time, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[71:40],
                                 m_tdata[103:72], m_tdata[104], m_tlast);
                    end
                end
                stall = (accepted_words / 120) % 3 == 0 ? 0 : $urandom_range(0, 12);
            end
            // one long hold-off to back the block up
            if (!hold_done && accepted_words >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() == 0 && !offering && expected_events.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(4 * 3_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/edf_pkg.sv
hw/rtl/edf_ram.sv
hw/rtl/edf_ctrl.sv
hw/rtl/edf_dpath.sv
hw/rtl/preemptive_edf_scheduler.sv
hw/rtl/edf_checker.sv
tb/sv/testbench.sv
